// File: rtl/core/tot_pkg.sv
// ----------------------------------------------------------------------------
// tot_pkg: shared types and constants of the thruster overcurrent trip unit
// Field widths, command kinds, config register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tot_pkg;

    localparam int unsigned MOTORS            = 6;
    localparam int unsigned MIDX_W            = 3;
    localparam int unsigned SAMPLE_W          = 12;
    localparam int unsigned SPEED_W           = 8;
    localparam int unsigned ACTION_W          = 3;
    localparam int unsigned GAIN_W            = 16;
    localparam int unsigned CAL_W             = 16;
    localparam int unsigned CAL_FRAC          = 12;
    localparam int unsigned LIMIT_W           = 15;
    localparam int unsigned DEF_HISTORY_DEPTH = 16;
    localparam int unsigned QUEUE_DEPTH       = 4;

    localparam logic [MIDX_W-1:0] MIDX_LAST = MIDX_W'(MOTORS - 1);

    // speed allowance: floor(speed_gain * speed / 6) by reciprocal
    localparam int unsigned SPD_PROD_W    = 2 * SPEED_W;
    localparam int unsigned SPD_DIV       = 6;
    localparam int unsigned SPD_DIV_SHIFT = SPD_PROD_W + $clog2(SPD_DIV);
    localparam int unsigned SPD_DIV_MUL_W = SPD_PROD_W + 1;
    localparam logic [SPD_DIV_MUL_W-1:0] SPD_DIV_MUL =
        SPD_DIV_MUL_W'((64'd1 << SPD_DIV_SHIFT) / SPD_DIV + 1);

    localparam logic [SPEED_W-1:0] BASE_OFF   = 8'hFF;
    localparam logic [LIMIT_W-1:0] BASE_SCALE = 15'd40;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_SWEEP = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_SPEED = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_ON    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_OFF   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_KILL  = 3'd4;

    // config port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_GAIN   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_OFFSET = 2'd3;

    localparam logic [SPEED_W-1:0]       RST_SPEED_GAIN     = 8'd0;
    localparam logic [SPEED_W-1:0]       RST_BASE_LIMIT     = 8'd255;
    localparam logic [GAIN_W-1:0]        RST_CURRENT_GAIN   = 16'd30571;
    localparam logic signed [CAL_W-1:0]  RST_CURRENT_OFFSET = 16'shF3E6;

    // stream packing
    localparam int unsigned IN_DATA_W    = 88;
    localparam int unsigned OUT_DATA_W   = 16;
    localparam int unsigned IN_IDX_LSB   = MOTORS * SAMPLE_W;
    localparam int unsigned IN_SPEED_LSB = IN_IDX_LSB + MIDX_W;
    localparam int unsigned IN_USED_W    = IN_SPEED_LSB + SPEED_W;

    typedef logic [MOTORS-1:0][SAMPLE_W-1:0] samples_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_SWEEP,
        CMD_SPEED,
        CMD_ON,
        CMD_OFF,
        CMD_KILL
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [MIDX_W-1:0]    idx;
        logic [MOTORS-1:0]    bit_mask;
        logic [SPEED_W-1:0]   speed;
        samples_t             samples;
    } cmd_t;

    typedef struct packed {
        logic              valid;
        logic [MIDX_W-1:0] idx;
        logic              over;
    } chk_res_t;

endpackage

`default_nettype wire

// File: rtl/core/tot_front.sv
// ----------------------------------------------------------------------------
// tot_front: input stage
// Takes input beats, decodes the action into a command and holds it for the
// queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tot_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic [tot_pkg::ACTION_W-1:0]     action,
    input  wire tot_pkg::samples_t                samples,
    input  wire logic [tot_pkg::MIDX_W-1:0]       motor_index,
    input  wire logic [tot_pkg::SPEED_W-1:0]      speed_value,
    output tot_pkg::cmd_t                         cmd,
    output logic                                  cmd_valid,
    input  wire logic                             cmd_ready
);

    logic           valid_reg;
    tot_pkg::cmd_t  cmd_reg;
    tot_pkg::cmd_t  cmd_next;
    logic           idx_ok;

    assign idx_ok   = motor_index < tot_pkg::MIDX_W'(tot_pkg::MOTORS);
    assign in_ready = !valid_reg || cmd_ready;

    always_comb
    begin
        cmd_next.idx      = motor_index;
        cmd_next.bit_mask = idx_ok ? (tot_pkg::MOTORS'(1) << motor_index) : '0;
        cmd_next.speed    = speed_value;
        cmd_next.samples  = samples;
        unique case (action)
            tot_pkg::ACT_SWEEP: cmd_next.kind = tot_pkg::CMD_SWEEP;
            tot_pkg::ACT_SPEED: cmd_next.kind = idx_ok ? tot_pkg::CMD_SPEED : tot_pkg::CMD_NOP;
            tot_pkg::ACT_ON:    cmd_next.kind = idx_ok ? tot_pkg::CMD_ON : tot_pkg::CMD_NOP;
            tot_pkg::ACT_OFF:   cmd_next.kind = idx_ok ? tot_pkg::CMD_OFF : tot_pkg::CMD_NOP;
            tot_pkg::ACT_KILL:  cmd_next.kind = tot_pkg::CMD_KILL;
            default:            cmd_next.kind = tot_pkg::CMD_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign cmd       = cmd_reg;
    assign cmd_valid = valid_reg;

endmodule

`default_nettype wire

// File: rtl/core/tot_queue.sv
// ----------------------------------------------------------------------------
// tot_queue: command queue
// Short FIFO between the decode stage and the execution stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tot_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tot_pkg::cmd_t push_cmd,
    input  wire logic          push_valid,
    output logic               push_ready,
    output tot_pkg::cmd_t      pop_cmd,
    output logic               pop_valid,
    input  wire logic          pop_ready
);

    localparam int unsigned QW = $clog2(tot_pkg::QUEUE_DEPTH);

    tot_pkg::cmd_t  entry_reg [tot_pkg::QUEUE_DEPTH];
    logic [QW:0]    wr_ptr_reg;
    logic [QW:0]    rd_ptr_reg;
    logic           full;
    logic           empty;

    assign empty = wr_ptr_reg == rd_ptr_reg;
    assign full  = (wr_ptr_reg[QW] != rd_ptr_reg[QW]) &&
                   (wr_ptr_reg[QW-1:0] == rd_ptr_reg[QW-1:0]);

    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign pop_cmd    = entry_reg[rd_ptr_reg[QW-1:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (push_valid && push_ready)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_valid && pop_ready)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid && push_ready)
        begin
            entry_reg[wr_ptr_reg[QW-1:0]] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/tot_check.sv
// ----------------------------------------------------------------------------
// tot_check: overcurrent check pipeline
// Three stages: average and speed product, calibration and allowance products,
// saturation and limit sum. One motor enters per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tot_check #(
    parameter int unsigned HISTORY_DEPTH = tot_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                iss_valid,
    input  wire logic [tot_pkg::MIDX_W-1:0]          iss_idx,
    input  wire logic [tot_pkg::SAMPLE_W+$clog2(HISTORY_DEPTH)-1:0] iss_sum,
    input  wire logic [tot_pkg::SPEED_W-1:0]         iss_speed,
    input  wire logic [tot_pkg::SPEED_W-1:0]         speed_gain,
    input  wire logic [tot_pkg::SPEED_W-1:0]         base_limit,
    input  wire logic [tot_pkg::GAIN_W-1:0]          current_gain,
    input  wire logic signed [tot_pkg::CAL_W-1:0]    current_offset,
    output tot_pkg::chk_res_t                        res
);

    localparam int unsigned POS_W      = $clog2(HISTORY_DEPTH);
    localparam int unsigned SUM_W      = tot_pkg::SAMPLE_W + POS_W;
    localparam int unsigned AVG_SHIFT  = SUM_W + POS_W;
    localparam int unsigned AVG_MUL_W  = SUM_W + 2;
    localparam int unsigned AVG_PROD_W = SUM_W + AVG_MUL_W;
    localparam logic [AVG_MUL_W-1:0] AVG_MUL =
        AVG_MUL_W'((64'd1 << AVG_SHIFT) / HISTORY_DEPTH + 64'd1);
    localparam int unsigned SCALED_W   = tot_pkg::SAMPLE_W + tot_pkg::GAIN_W;
    localparam int unsigned LIM_PROD_W = tot_pkg::SPD_PROD_W + tot_pkg::SPD_DIV_MUL_W;
    localparam int unsigned CAL_SUM_W  = tot_pkg::CAL_W + 2;

    logic                              s1_valid_reg;
    logic                              s2_valid_reg;
    logic                              s3_valid_reg;
    logic [tot_pkg::MIDX_W-1:0]        s1_idx_reg;
    logic [tot_pkg::MIDX_W-1:0]        s2_idx_reg;
    logic [tot_pkg::MIDX_W-1:0]        s3_idx_reg;
    logic [AVG_PROD_W-1:0]             avg_prod_reg;
    logic [tot_pkg::SPD_PROD_W-1:0]    spd_prod_reg;
    logic [SCALED_W-1:0]               scaled_reg;
    logic [LIM_PROD_W-1:0]             lim_prod_reg;
    logic [tot_pkg::CAL_W-1:0]         cal_reg;
    logic [tot_pkg::LIMIT_W-1:0]       limit_reg;

    logic [tot_pkg::SAMPLE_W-1:0]      avg;
    logic [tot_pkg::CAL_W-1:0]         scaled_hi;
    logic signed [CAL_SUM_W-1:0]       cal_sum;
    logic [tot_pkg::CAL_W-1:0]         cal_sat;
    logic [tot_pkg::LIMIT_W-1:0]       spd_allow;
    logic [tot_pkg::LIMIT_W-1:0]       base_allow;

    assign avg       = tot_pkg::SAMPLE_W'(avg_prod_reg >> AVG_SHIFT);
    assign scaled_hi = tot_pkg::CAL_W'(scaled_reg >> tot_pkg::CAL_FRAC);
    assign cal_sum   = $signed({2'b00, scaled_hi}) +
                       $signed({{2{current_offset[tot_pkg::CAL_W-1]}}, current_offset});
    assign spd_allow  = tot_pkg::LIMIT_W'(lim_prod_reg >> tot_pkg::SPD_DIV_SHIFT);
    assign base_allow = tot_pkg::LIMIT_W'(base_limit) * tot_pkg::BASE_SCALE;

    always_comb
    begin
        if (cal_sum[CAL_SUM_W-1])
        begin
            cal_sat = '0;
        end
        else if (cal_sum[CAL_SUM_W-2])
        begin
            cal_sat = '1;
        end
        else
        begin
            cal_sat = cal_sum[tot_pkg::CAL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= iss_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg   <= iss_idx;
        avg_prod_reg <= AVG_PROD_W'(iss_sum) * AVG_PROD_W'(AVG_MUL);
        spd_prod_reg <= tot_pkg::SPD_PROD_W'(iss_speed) * tot_pkg::SPD_PROD_W'(speed_gain);

        s2_idx_reg   <= s1_idx_reg;
        scaled_reg   <= SCALED_W'(avg) * SCALED_W'(current_gain);
        lim_prod_reg <= LIM_PROD_W'(spd_prod_reg) * LIM_PROD_W'(tot_pkg::SPD_DIV_MUL);

        s3_idx_reg   <= s2_idx_reg;
        cal_reg      <= cal_sat;
        limit_reg    <= spd_allow + base_allow;
    end

    assign res.valid = s3_valid_reg;
    assign res.idx   = s3_idx_reg;
    assign res.over  = cal_reg > tot_pkg::CAL_W'(limit_reg);

endmodule

`default_nettype wire

// File: rtl/core/tot_back.sv
// ----------------------------------------------------------------------------
// tot_back: execution stage
// Sample history ring, running sums, speeds and trip state; holds the result
// beat; checks all motors for overcurrent on a wrap if base_limit != BASE_OFF.
// ----------------------------------------------------------------------------
`default_nettype none

module tot_back #(
    parameter int unsigned HISTORY_DEPTH = tot_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire tot_pkg::cmd_t                     cmd,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire logic [tot_pkg::SPEED_W-1:0]       speed_gain,
    input  wire logic [tot_pkg::SPEED_W-1:0]       base_limit,
    input  wire logic [tot_pkg::GAIN_W-1:0]        current_gain,
    input  wire logic signed [tot_pkg::CAL_W-1:0]  current_offset,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [tot_pkg::MOTORS-1:0]             enable_mask,
    output logic [tot_pkg::MOTORS-1:0]             trip_mask,
    output logic                                   overcurrent_led
);

    localparam int unsigned POS_W = $clog2(HISTORY_DEPTH);
    localparam int unsigned SUM_W = tot_pkg::SAMPLE_W + POS_W;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);

    typedef enum logic {
        ST_RUN,
        ST_CHECK
    } state_t;

    state_t                          state_reg,      state_next;
    logic [POS_W-1:0]                pos_reg,        pos_next;
    logic                            fill_reg,       fill_next;
    logic                            stage_valid_reg, stage_valid_next;
    logic [SUM_W-1:0]                sum_reg   [tot_pkg::MOTORS];
    logic [SUM_W-1:0]                sum_next  [tot_pkg::MOTORS];
    logic [tot_pkg::SPEED_W-1:0]     speed_reg [tot_pkg::MOTORS];
    logic [tot_pkg::SPEED_W-1:0]     speed_next[tot_pkg::MOTORS];
    logic [tot_pkg::MOTORS-1:0]      strike_reg,     strike_next;
    logic [tot_pkg::MOTORS-1:0]      trip_reg,       trip_next;
    logic [tot_pkg::MOTORS-1:0]      en_reg,         en_next;
    logic [tot_pkg::MIDX_W-1:0]      iss_cnt_reg,    iss_cnt_next;
    logic                            iss_left_reg,   iss_left_next;
    logic                            out_valid_reg,  out_valid_next;
    logic [tot_pkg::MOTORS-1:0]      out_en_reg,     out_en_next;
    logic [tot_pkg::MOTORS-1:0]      out_trip_reg,   out_trip_next;
    logic                            out_led_reg,    out_led_next;

    tot_pkg::samples_t               hist_mem [HISTORY_DEPTH];
    tot_pkg::samples_t               rd_data_reg;
    tot_pkg::cmd_t                   stage_cmd_reg;
    logic [POS_W-1:0]                stage_pos_reg;
    logic                            stage_fill_reg;

    tot_pkg::samples_t               old_sample;
    tot_pkg::chk_res_t               chk_res;
    logic                            exec;
    logic                            load;
    logic                            mem_we;
    logic                            wrap_check;
    logic                            iss_valid;

    assign exec = (state_reg == ST_RUN) && stage_valid_reg && (!out_valid_reg || out_ready);
    assign load = cmd_valid && (!stage_valid_reg || exec);
    assign cmd_ready  = load;
    assign iss_valid  = (state_reg == ST_CHECK) && iss_left_reg;
    assign old_sample = stage_fill_reg ? rd_data_reg : '0;
    assign wrap_check = (stage_cmd_reg.kind == tot_pkg::CMD_SWEEP) &&
                        (stage_pos_reg == POS_LAST) && (base_limit != tot_pkg::BASE_OFF);

    tot_check #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .iss_valid      (iss_valid),
        .iss_idx        (iss_cnt_reg),
        .iss_sum        (sum_reg[iss_cnt_reg]),
        .iss_speed      (speed_reg[iss_cnt_reg]),
        .speed_gain     (speed_gain),
        .base_limit     (base_limit),
        .current_gain   (current_gain),
        .current_offset (current_offset),
        .res            (chk_res)
    );

    always_comb
    begin
        state_next       = state_reg;
        pos_next         = pos_reg;
        fill_next        = fill_reg;
        stage_valid_next = stage_valid_reg;
        strike_next      = strike_reg;
        trip_next        = trip_reg;
        en_next          = en_reg;
        iss_cnt_next     = iss_cnt_reg;
        iss_left_next    = iss_left_reg;
        out_valid_next   = out_valid_reg;
        out_en_next      = out_en_reg;
        out_trip_next    = out_trip_reg;
        out_led_next     = out_led_reg;
        mem_we           = 1'b0;
        for (int m = 0; m < tot_pkg::MOTORS; m++)
        begin
            sum_next[m]   = sum_reg[m];
            speed_next[m] = speed_reg[m];
        end

        if (load)
        begin
            stage_valid_next = 1'b1;
            if (cmd.kind == tot_pkg::CMD_SWEEP)
            begin
                if (pos_reg == POS_LAST)
                begin
                    pos_next  = '0;
                    fill_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
        else if (exec)
        begin
            stage_valid_next = 1'b0;
        end

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (exec)
        begin
            unique case (stage_cmd_reg.kind)
                tot_pkg::CMD_SWEEP:
                begin
                    for (int m = 0; m < tot_pkg::MOTORS; m++)
                    begin
                        sum_next[m] = sum_reg[m] - SUM_W'(old_sample[m]) +
                                      SUM_W'(stage_cmd_reg.samples[m]);
                    end
                    mem_we = 1'b1;
                end
                tot_pkg::CMD_SPEED:
                begin
                    speed_next[stage_cmd_reg.idx] = stage_cmd_reg.speed;
                end
                tot_pkg::CMD_ON:
                begin
                    if ((trip_reg & stage_cmd_reg.bit_mask) == '0)
                    begin
                        en_next = en_reg | stage_cmd_reg.bit_mask;
                    end
                end
                tot_pkg::CMD_OFF:
                begin
                    en_next   = en_reg & ~stage_cmd_reg.bit_mask;
                    trip_next = trip_reg & ~stage_cmd_reg.bit_mask;
                end
                tot_pkg::CMD_KILL:
                begin
                    en_next   = '0;
                    trip_next = '0;
                end
                tot_pkg::CMD_NOP:
                begin
                end
                default:
                begin
                end
            endcase

            if (wrap_check)
            begin
                state_next    = ST_CHECK;
                iss_cnt_next  = '0;
                iss_left_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_en_next    = en_next;
                out_trip_next  = trip_next;
                out_led_next   = |trip_next;
            end
        end

        if (iss_valid)
        begin
            if (iss_cnt_reg == tot_pkg::MIDX_LAST)
            begin
                iss_left_next = 1'b0;
            end
            else
            begin
                iss_cnt_next = iss_cnt_reg + 1'b1;
            end
        end

        // two overlimit checks in a row latch the trip
        if (chk_res.valid)
        begin
            if (chk_res.over)
            begin
                if (strike_reg[chk_res.idx])
                begin
                    trip_next[chk_res.idx] = 1'b1;
                end
                else
                begin
                    strike_next[chk_res.idx] = 1'b1;
                end
            end
            else
            begin
                strike_next[chk_res.idx] = 1'b0;
            end

            if (chk_res.idx == tot_pkg::MIDX_LAST)
            begin
                en_next        = en_reg & ~trip_next;
                out_valid_next = 1'b1;
                out_en_next    = en_next;
                out_trip_next  = trip_next;
                out_led_next   = |trip_next;
                state_next     = ST_RUN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            pos_reg         <= '0;
            fill_reg        <= 1'b0;
            stage_valid_reg <= 1'b0;
            strike_reg      <= '0;
            trip_reg        <= '0;
            en_reg          <= '0;
            iss_cnt_reg     <= '0;
            iss_left_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_en_reg      <= '0;
            out_trip_reg    <= '0;
            out_led_reg     <= 1'b0;
            for (int m = 0; m < tot_pkg::MOTORS; m++)
            begin
                sum_reg[m]   <= '0;
                speed_reg[m] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            pos_reg         <= pos_next;
            fill_reg        <= fill_next;
            stage_valid_reg <= stage_valid_next;
            strike_reg      <= strike_next;
            trip_reg        <= trip_next;
            en_reg          <= en_next;
            iss_cnt_reg     <= iss_cnt_next;
            iss_left_reg    <= iss_left_next;
            out_valid_reg   <= out_valid_next;
            out_en_reg      <= out_en_next;
            out_trip_reg    <= out_trip_next;
            out_led_reg     <= out_led_next;
            for (int m = 0; m < tot_pkg::MOTORS; m++)
            begin
                sum_reg[m]   <= sum_next[m];
                speed_reg[m] <= speed_next[m];
            end
        end
    end

    // history ring: read on load, written when the sweep executes
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[stage_pos_reg] <= stage_cmd_reg.samples;
        end
        if (load)
        begin
            rd_data_reg    <= hist_mem[pos_reg];
            stage_cmd_reg  <= cmd;
            stage_pos_reg  <= pos_reg;
            stage_fill_reg <= fill_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign enable_mask     = out_en_reg;
    assign trip_mask       = out_trip_reg;
    assign overcurrent_led = out_led_reg;

endmodule

`default_nettype wire

// File: rtl/core/thruster_overcurrent_trip_unit.sv
// ----------------------------------------------------------------------------
// thruster_overcurrent_trip_unit: overcurrent protection for six thrusters
// Path: front register, command queue, execution stage, result register; a
// sweep that wraps the ring with protection on also runs six motors through
// the 3-stage check pipeline. Otherwise one beat per cycle if m_axis is ready.
// Reset: asynchronous, active low; history reads as zero until the ring has
// wrapped once, so no clearing pass is run.
// ----------------------------------------------------------------------------
`default_nettype none

module thruster_overcurrent_trip_unit #(
    parameter int unsigned HISTORY_DEPTH = tot_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // sample_m0..sample_m5, motor_index, speed_value, zero pad
    input  wire logic [tot_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // action
    input  wire logic [tot_pkg::ACTION_W-1:0]       s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // enable_mask, trip_mask, overcurrent_led, zero pad
    output logic [tot_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [tot_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [tot_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [tot_pkg::SPEED_W-1:0]        speed_gain_reg;
    logic [tot_pkg::SPEED_W-1:0]        base_limit_reg;
    logic [tot_pkg::GAIN_W-1:0]         current_gain_reg;
    logic signed [tot_pkg::CAL_W-1:0]   current_offset_reg;

    tot_pkg::cmd_t                      front_cmd;
    logic                               front_valid;
    logic                               front_ready;
    tot_pkg::cmd_t                      queue_cmd;
    logic                               queue_valid;
    logic                               queue_ready;
    logic [tot_pkg::MOTORS-1:0]         enable_mask;
    logic [tot_pkg::MOTORS-1:0]         trip_mask;
    logic                               overcurrent_led;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg     <= tot_pkg::RST_SPEED_GAIN;
            base_limit_reg     <= tot_pkg::RST_BASE_LIMIT;
            current_gain_reg   <= tot_pkg::RST_CURRENT_GAIN;
            current_offset_reg <= tot_pkg::RST_CURRENT_OFFSET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tot_pkg::CFG_SPEED_GAIN:     speed_gain_reg     <= cfg_data[tot_pkg::SPEED_W-1:0];
                tot_pkg::CFG_BASE_LIMIT:     base_limit_reg     <= cfg_data[tot_pkg::SPEED_W-1:0];
                tot_pkg::CFG_CURRENT_GAIN:   current_gain_reg   <= cfg_data;
                tot_pkg::CFG_CURRENT_OFFSET: current_offset_reg <= $signed(cfg_data);
                default:
                begin
                end
            endcase
        end
    end

    tot_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .action      (s_axis_tuser),
        .samples     (s_axis_tdata[tot_pkg::IN_IDX_LSB-1:0]),
        .motor_index (s_axis_tdata[tot_pkg::IN_SPEED_LSB-1:tot_pkg::IN_IDX_LSB]),
        .speed_value (s_axis_tdata[tot_pkg::IN_USED_W-1:tot_pkg::IN_SPEED_LSB]),
        .cmd         (front_cmd),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready)
    );

    tot_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (front_cmd),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_cmd    (queue_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready)
    );

    tot_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (queue_cmd),
        .cmd_valid       (queue_valid),
        .cmd_ready       (queue_ready),
        .speed_gain      (speed_gain_reg),
        .base_limit      (base_limit_reg),
        .current_gain    (current_gain_reg),
        .current_offset  (current_offset_reg),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .enable_mask     (enable_mask),
        .trip_mask       (trip_mask),
        .overcurrent_led (overcurrent_led)
    );

    assign m_axis_tdata = tot_pkg::OUT_DATA_W'({overcurrent_led, trip_mask, enable_mask});

endmodule

`default_nettype wire
